[hw/rtl/wpd_pkg.sv]
package wpd_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int ACC_W        = 40;
	localparam int CNT_W        = 17;
	localparam int DIVIDEND_W   = 40;
	localparam int DIVISOR_W    = 24;

	localparam logic [22:0] MAX23   = 23'h7FFFFF;
	localparam logic [21:0] POS_MAX = 22'h3FFFFF;

	localparam logic [15:0] WINDOW_LEN_RST = 16'd512;
	localparam logic [6:0]  DECIMATION_RST = 7'd1;
	localparam logic [22:0] THRESHOLD_RST  = 23'd2560;
	localparam logic [1:0]  TAG_RST        = 2'd0;

	typedef enum logic [1:0] {
		REG_WINDOW_LEN = 2'd0,
		REG_DECIMATION = 2'd1,
		REG_THRESHOLD  = 2'd2,
		REG_TAG        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_MEAN = 2'd0,
		OP_MABS = 2'd1,
		OP_RPM  = 2'd2,
		OP_RPMA = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last_sample;
	} in_t;

	typedef struct packed {
		logic [22:0]        peak_value;
		logic [21:0]        peak_position;
		logic signed [23:0] mean_value;
		logic [22:0]        mean_abs;
		logic signed [23:0] peak_to_mean;
		logic [22:0]        peak_to_mean_abs;
		logic               detected;
		logic [1:0]         tag_out;
		logic [15:0]        block_index;
		logic               last_block;
		logic               div_fault;
	} out_t;

	typedef struct packed {
		logic acc;
		logic close;
		logic div_start;
		logic store;
		logic out_load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic closes;
		logic div_done;
		logic out_busy;
	} sts_t;

	function automatic logic signed [23:0] sat_s24(logic [DIVIDEND_W-1:0] mag, logic neg);
		logic signed [23:0] r;
		if (neg) begin
			if (mag > DIVIDEND_W'(24'h800000))
				r = 24'sh800000;
			else
				r = 24'(~mag[23:0] + 24'd1);
		end else begin
			if (mag > DIVIDEND_W'(MAX23))
				r = 24'sh7FFFFF;
			else
				r = mag[23:0];
		end
		return r;
	endfunction

	function automatic logic [22:0] sat_u23(logic [DIVIDEND_W-1:0] q);
		logic [22:0] r;
		if (q > DIVIDEND_W'(MAX23))
			r = MAX23;
		else
			r = q[22:0];
		return r;
	endfunction

endpackage

[hw/rtl/wpd_div.sv]
module wpd_div import wpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  run_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(DIVIDEND_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/wpd_dp.sv]
module wpd_dp import wpd_pkg::*; #(
	parameter int MAX_SEQUENCE_LEN = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [22:0] cfg_wdata,
	input  in_t         in_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	localparam int IDX_W  = $clog2(MAX_SEQUENCE_LEN);
	localparam int PROD_W = IDX_W + 7;
	localparam int PW     = (PROD_W > 22) ? PROD_W : 22;

	logic [15:0] window_len_q;
	logic [6:0]  decimation_q;
	logic [22:0] threshold_q;
	logic [1:0]  tag_q;

	logic [IDX_W-1:0]        sample_index_q;
	logic [CNT_W-1:0]        count_q;
	logic [22:0]             peak_q;
	logic [IDX_W-1:0]        peak_idx_q;
	logic signed [ACC_W-1:0] sum_q;
	logic [ACC_W-1:0]        abs_q;
	logic [15:0]             block_q;

	logic [22:0]             h_peak_q;
	logic [IDX_W-1:0]        h_idx_q;
	logic                    h_sum_neg_q;
	logic [ACC_W-1:0]        h_sum_mag_q;
	logic [ACC_W-1:0]        h_abs_q;
	logic [CNT_W-1:0]        h_cnt_q;
	logic                    h_last_q;
	logic [15:0]             h_block_q;

	logic signed [23:0]      mean_q;
	logic [22:0]             mabs_q;
	logic signed [23:0]      rpm_q;
	logic [22:0]             rpma_q;
	logic                    fault_q;

	out_t                    out_q;
	logic                    out_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] s;
	logic [SAMPLE_WIDTH-1:0]        s_mag;
	logic                           s_gt;
	logic [22:0]                    peak_nxt;
	logic [IDX_W-1:0]               pidx_nxt;
	logic signed [ACC_W-1:0]        sum_nxt;
	logic [ACC_W-1:0]               abs_nxt;
	logic [CNT_W-1:0]               cnt_nxt;
	logic [CNT_W-1:0]               wl;
	logic                           idx_wrap;

	logic [DIVIDEND_W-1:0]          div_a;
	logic [DIVISOR_W-1:0]           div_b;
	logic [DIVIDEND_W-1:0]          quot;
	logic                           div_done;
	logic [23:0]                    mean_mag;
	logic [PW-1:0]                  prod;
	logic [21:0]                    pos;
	out_t                           rec;

	always_comb begin
		s        = in_data.sample;
		s_mag    = s[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-s) : SAMPLE_WIDTH'(s);
		s_gt     = !s[SAMPLE_WIDTH-1] && (s[22:0] > peak_q);
		peak_nxt = s_gt ? s[22:0] : peak_q;
		pidx_nxt = s_gt ? sample_index_q : peak_idx_q;
		sum_nxt  = sum_q + ACC_W'(s);
		abs_nxt  = abs_q + ACC_W'(s_mag);
		cnt_nxt  = count_q + CNT_W'(1);
		wl       = (window_len_q == 16'd0) ? CNT_W'(1) : CNT_W'(window_len_q);
		idx_wrap = sample_index_q == IDX_W'(MAX_SEQUENCE_LEN - 1);
	end

	assign sts.closes   = in_data.last_sample || (cnt_nxt >= wl);
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			decimation_q <= DECIMATION_RST;
			threshold_q  <= THRESHOLD_RST;
			tag_q        <= TAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_wdata[15:0];
				REG_DECIMATION: decimation_q <= cfg_wdata[6:0];
				REG_THRESHOLD:  threshold_q  <= cfg_wdata;
				REG_TAG:        tag_q        <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			count_q        <= '0;
			peak_q         <= '0;
			peak_idx_q     <= '0;
			sum_q          <= '0;
			abs_q          <= '0;
			block_q        <= '0;
		end else if (cmd.acc) begin
			sample_index_q <= (in_data.last_sample || idx_wrap) ? '0
				: sample_index_q + IDX_W'(1);
			if (cmd.close) begin
				count_q    <= '0;
				peak_q     <= '0;
				peak_idx_q <= '0;
				sum_q      <= '0;
				abs_q      <= '0;
				block_q    <= in_data.last_sample ? 16'd0 : block_q + 16'd1;
			end else begin
				count_q    <= cnt_nxt;
				peak_q     <= peak_nxt;
				peak_idx_q <= pidx_nxt;
				sum_q      <= sum_nxt;
				abs_q      <= abs_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && cmd.close) begin
			h_peak_q    <= peak_nxt;
			h_idx_q     <= pidx_nxt;
			h_sum_neg_q <= sum_nxt[ACC_W-1];
			h_sum_mag_q <= sum_nxt[ACC_W-1] ? ACC_W'(-sum_nxt) : ACC_W'(sum_nxt);
			h_abs_q     <= abs_nxt;
			h_cnt_q     <= cnt_nxt;
			h_last_q    <= in_data.last_sample;
			h_block_q   <= block_q;
		end
	end

	always_comb begin
		mean_mag = mean_q[23] ? 24'(-mean_q) : 24'(mean_q);
		case (cmd.op)
			OP_MEAN: begin
				div_a = h_sum_mag_q;
				div_b = DIVISOR_W'(h_cnt_q);
			end
			OP_MABS: begin
				div_a = h_abs_q;
				div_b = DIVISOR_W'(h_cnt_q);
			end
			OP_RPM: begin
				div_a = DIVIDEND_W'({h_peak_q, 8'h00});
				div_b = mean_mag;
			end
			OP_RPMA: begin
				div_a = DIVIDEND_W'({h_peak_q, 8'h00});
				div_b = DIVISOR_W'(mabs_q);
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	wpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.acc && cmd.close)
			fault_q <= 1'b0;
		if (cmd.store) begin
			case (cmd.op)
				OP_MEAN: mean_q <= sat_s24(quot, h_sum_neg_q);
				OP_MABS: mabs_q <= sat_u23(quot);
				OP_RPM: begin
					if (mean_q == 24'sd0) begin
						rpm_q   <= (h_peak_q != 23'd0) ? 24'sh7FFFFF : 24'sd0;
						fault_q <= 1'b1;
					end else begin
						rpm_q <= sat_s24(quot, mean_q[23]);
					end
				end
				OP_RPMA: begin
					if (mabs_q == 23'd0) begin
						rpma_q  <= (h_peak_q != 23'd0) ? MAX23 : 23'd0;
						fault_q <= 1'b1;
					end else begin
						rpma_q <= sat_u23(quot);
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		prod = PW'(h_idx_q) * PW'(decimation_q);
		pos  = (prod > PW'(POS_MAX)) ? POS_MAX : prod[21:0];

		rec.peak_value       = h_peak_q;
		rec.peak_position    = pos;
		rec.mean_value       = mean_q;
		rec.mean_abs         = mabs_q;
		rec.peak_to_mean     = rpm_q;
		rec.peak_to_mean_abs = rpma_q;
		rec.detected         = rpma_q > threshold_q;
		rec.tag_out          = tag_q;
		rec.block_index      = h_block_q;
		rec.last_block       = h_last_q;
		rec.div_fault        = fault_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= rec;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/wpd_ctrl.sv]
module wpd_ctrl import wpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_WAIT  = 4'b0100,
		S_PUB   = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	op_t    op_q, op_nxt;

	always_comb begin
		state_nxt     = state_q;
		op_nxt        = op_q;
		cmd.acc       = 1'b0;
		cmd.close     = 1'b0;
		cmd.div_start = 1'b0;
		cmd.store     = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.op        = op_q;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (sts.closes) begin
						cmd.close = 1'b1;
						op_nxt    = OP_MEAN;
						state_nxt = S_START;
					end
				end
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_WAIT;
			end
			S_WAIT: begin
				if (sts.div_done) begin
					cmd.store = 1'b1;
					case (op_q)
						OP_MEAN: begin
							op_nxt    = OP_MABS;
							state_nxt = S_START;
						end
						OP_MABS: begin
							op_nxt    = OP_RPM;
							state_nxt = S_START;
						end
						OP_RPM: begin
							op_nxt    = OP_RPMA;
							state_nxt = S_START;
						end
						default: state_nxt = S_PUB;
					endcase
				end
			end
			S_PUB: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_MEAN;
		end else begin
			state_q <= state_nxt;
			op_q    <= op_nxt;
		end
	end

endmodule

[hw/rtl/windowed_peak_detector.sv]
// Windowed peak-to-average detector. Samples are taken on in_valid/in_ready and
// cut into windows of window_len samples (a window also closes on last_sample).
// A sample that does not close a window leaves in_ready high. A closing sample
// starts four divisions (mean, mean-abs, peak/mean, peak/mean-abs) on one shared
// 40-step restoring divider, during which in_ready is low; the record goes into
// an output register, so the next window starts filling while the record waits
// for out_ready. The user must write configuration through cfg_we/cfg_index/
// cfg_wdata only while no window record is being computed; it is not enforced.
module windowed_peak_detector import wpd_pkg::*; #(
	parameter int MAX_SEQUENCE_LEN = 65536
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  reg_idx_t cfg_index,
	input  logic [22:0] cfg_wdata,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_t      in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_t     out_data
);

	cmd_t cmd;
	sts_t sts;

	wpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wpd_dp #(
		.MAX_SEQUENCE_LEN (MAX_SEQUENCE_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hw/rtl/wpd_checker.sv]
module wpd_checker import wpd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input in_t      in_data,
	input logic     out_valid,
	input logic     out_ready,
	input out_t     out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word dropped or changed while stalled");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_sample |=> !in_ready)
		else $error("last sample did not start a window record");

	a_detect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.detected |-> out_data.peak_to_mean_abs != 23'd0)
		else $error("detect flag set with zero ratio");

	a_no_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.peak_value == 23'd0 |-> out_data.peak_position == 22'd0)
		else $error("position reported without a peak");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_fault
		|-> out_data.mean_value == 24'sd0 || out_data.mean_abs == 23'd0)
		else $error("divide fault without a zero mean");

endmodule

bind windowed_peak_detector wpd_checker u_wpd_checker (.*);
